/* rtl/mdaa_pkg.sv */
package mdaa_pkg;

    localparam int MAX_DIMS    = 8;
    localparam int STORE_DEPTH = 4096;
    localparam int ELEM_WIDTH  = 32;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int STRIDE_W    = ADDR_W + 1;
    localparam int DIM_W       = $clog2(MAX_DIMS);
    localparam int IDX_W       = 8;
    localparam int NDIM_REG_W  = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = MAX_DIMS * IDX_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_DIMS   = 2'd0,
        CFG_DIM_BOUNDS = 2'd1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BOUNDS   = 2'd1,
        ST_OVERSIZE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_INIT,
        CS_STEP
    } t_cfg_state;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_SCAN,
        FS_PUSH
    } t_front_state;

    // array geometry as seen by the front end
    typedef struct packed {
        logic [MAX_DIMS-1:0][STRIDE_W-1:0] stride;
        logic [MAX_DIMS-1:0][IDX_W-1:0]    bound;
        logic [DIM_W-1:0]                  last_dim;
        logic                              oversize;
        logic                              busy;
    } t_geom;

    typedef struct packed {
        logic                  is_write;
        logic [ELEM_WIDTH-1:0] wdata;
        logic [ADDR_W-1:0]     addr;
        t_status               status;
    } t_job;

    // index of the innermost dimension in use; zero acts as one, large values clamp
    function automatic logic [DIM_W-1:0] last_dim_of(input logic [NDIM_REG_W-1:0] n);
        logic [DIM_W-1:0] res;
        if (n == '0) begin
            res = '0;
        end else if (n > NDIM_REG_W'(MAX_DIMS)) begin
            res = DIM_W'(MAX_DIMS - 1);
        end else begin
            res = DIM_W'(n - 1'b1);
        end
        return res;
    endfunction

endpackage

/* rtl/mdaa_req_if.sv */
interface mdaa_req_if import mdaa_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic signed [ELEM_WIDTH-1:0] write_value;
    logic [IDX_W-1:0]         index_0;
    logic [IDX_W-1:0]         index_1;
    logic [IDX_W-1:0]         index_2;
    logic [IDX_W-1:0]         index_3;
    logic [IDX_W-1:0]         index_4;
    logic [IDX_W-1:0]         index_5;
    logic [IDX_W-1:0]         index_6;
    logic [IDX_W-1:0]         index_7;

    modport source (
        output valid, req_type, write_value,
        output index_0, index_1, index_2, index_3, index_4, index_5, index_6, index_7,
        input  ready
    );

    modport sink (
        input  valid, req_type, write_value,
        input  index_0, index_1, index_2, index_3, index_4, index_5, index_6, index_7,
        output ready
    );
endinterface

/* rtl/mdaa_rsp_if.sv */
interface mdaa_rsp_if import mdaa_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [ELEM_WIDTH-1:0] read_data;
    logic [ADDR_W-1:0]            element_address;
    logic [1:0]                   status;

    modport source (
        output valid, read_data, element_address, status,
        input  ready
    );

    modport sink (
        input  valid, read_data, element_address, status,
        output ready
    );
endinterface

/* rtl/mdaa_cfg.sv */
module mdaa_cfg import mdaa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_geom                 o_geom
);

    // multiply with saturation just above the store size; exact enough for the size check
    function automatic logic [STRIDE_W-1:0] sat_mul(input logic [STRIDE_W-1:0] a,
                                                    input logic [IDX_W-1:0] b);
        logic [STRIDE_W+IDX_W-1:0] p;
        p = (STRIDE_W+IDX_W)'(a) * (STRIDE_W+IDX_W)'(b);
        return (p > (STRIDE_W+IDX_W)'(STORE_DEPTH)) ? STRIDE_W'(STORE_DEPTH + 1)
                                                    : STRIDE_W'(p);
    endfunction

    t_cfg_state                         r_state, n_state;
    logic [NDIM_REG_W-1:0]              r_num_dims, n_num_dims;
    logic [MAX_DIMS-1:0][IDX_W-1:0]     r_bounds, n_bounds;
    logic [MAX_DIMS-1:0][STRIDE_W-1:0]  r_stride, n_stride;
    logic [STRIDE_W-1:0]                r_acc, n_acc;
    logic [DIM_W-1:0]                   r_d, n_d;
    logic                               r_over, n_over;
    logic [STRIDE_W-1:0]                prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= CS_IDLE;
            r_num_dims <= NDIM_REG_W'(1);
            r_bounds   <= '0;
            r_stride   <= {{(MAX_DIMS-1)*STRIDE_W{1'b0}}, STRIDE_W'(1)};
            r_acc      <= '0;
            r_d        <= '0;
            r_over     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_num_dims <= n_num_dims;
            r_bounds   <= n_bounds;
            r_stride   <= n_stride;
            r_acc      <= n_acc;
            r_d        <= n_d;
            r_over     <= n_over;
        end
    end

    assign prod = sat_mul(r_acc, r_bounds[r_d]);

    always_comb begin
        n_state    = r_state;
        n_num_dims = r_num_dims;
        n_bounds   = r_bounds;
        n_stride   = r_stride;
        n_acc      = r_acc;
        n_d        = r_d;
        n_over     = r_over;
        case (r_state)
            CS_IDLE: begin
            end
            CS_INIT: begin
                n_stride = '0;
                n_acc    = STRIDE_W'(1);
                n_d      = last_dim_of(r_num_dims);
                n_state  = CS_STEP;
            end
            CS_STEP: begin
                // innermost first: stride[d] = product of bounds inside d
                n_stride[r_d] = r_acc;
                n_acc         = prod;
                if (r_d == '0) begin
                    n_over  = prod > STRIDE_W'(STORE_DEPTH);
                    n_state = CS_IDLE;
                end else begin
                    n_d = r_d - 1'b1;
                end
            end
            default: n_state = CS_IDLE;
        endcase
        if (i_cfg_we) begin
            if (i_cfg_index == CFG_NUM_DIMS) begin
                n_num_dims = i_cfg_wdata[NDIM_REG_W-1:0];
                n_state    = CS_INIT;
            end else if (i_cfg_index == CFG_DIM_BOUNDS) begin
                n_bounds = i_cfg_wdata;
                n_state  = CS_INIT;
            end
        end
    end

    assign o_geom.stride   = r_stride;
    assign o_geom.bound    = r_bounds;
    assign o_geom.last_dim = last_dim_of(r_num_dims);
    assign o_geom.oversize = r_over;
    assign o_geom.busy     = (r_state != CS_IDLE);

endmodule

/* rtl/mdaa_front.sv */
module mdaa_front import mdaa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mdaa_req_if.sink   req,
    input  t_geom      i_geom,
    input  logic       i_full,
    output logic       o_push,
    output t_job       o_job
);

    t_front_state                    r_state, n_state;
    logic [DIM_W-1:0]                r_d, n_d;
    logic                            r_is_write, n_is_write;
    logic [ELEM_WIDTH-1:0]           r_wdata, n_wdata;
    logic [MAX_DIMS-1:0][IDX_W-1:0]  r_idx, n_idx;
    logic [ADDR_W-1:0]               r_addr, n_addr;
    t_status                         r_status, n_status;
    logic [IDX_W-1:0]                ix;
    logic [ADDR_W-1:0]               mac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d        <= n_d;
        r_is_write <= n_is_write;
        r_wdata    <= n_wdata;
        r_idx      <= n_idx;
        r_addr     <= n_addr;
        r_status   <= n_status;
    end

    assign req.ready = (r_state == FS_IDLE) && !i_geom.busy;

    assign ix  = r_idx[r_d];
    // address wraps modulo the store size, which is exact whenever it is used
    assign mac = r_addr + ADDR_W'(i_geom.stride[r_d] * STRIDE_W'(ix));

    always_comb begin
        n_state    = r_state;
        n_d        = r_d;
        n_is_write = r_is_write;
        n_wdata    = r_wdata;
        n_idx      = r_idx;
        n_addr     = r_addr;
        n_status   = r_status;
        o_push     = 1'b0;
        case (r_state)
            FS_IDLE: begin
                if (req.valid && req.ready) begin
                    n_is_write = req.req_type;
                    n_wdata    = req.write_value;
                    n_idx[0]   = req.index_0;
                    n_idx[1]   = req.index_1;
                    n_idx[2]   = req.index_2;
                    n_idx[3]   = req.index_3;
                    n_idx[4]   = req.index_4;
                    n_idx[5]   = req.index_5;
                    n_idx[6]   = req.index_6;
                    n_idx[7]   = req.index_7;
                    n_d        = '0;
                    n_addr     = '0;
                    n_state    = FS_SCAN;
                end
            end
            FS_SCAN: begin
                // one dimension per cycle, outermost first
                if (i_geom.oversize) begin
                    n_status = ST_OVERSIZE;
                    n_addr   = '0;
                    n_state  = FS_PUSH;
                end else if (ix >= i_geom.bound[r_d]) begin
                    n_status = ST_BOUNDS;
                    n_addr   = '0;
                    n_state  = FS_PUSH;
                end else begin
                    n_addr = mac;
                    if (r_d == i_geom.last_dim) begin
                        n_status = ST_OK;
                        n_state  = FS_PUSH;
                    end else begin
                        n_d = r_d + 1'b1;
                    end
                end
            end
            FS_PUSH: begin
                o_push = !i_full;
                if (!i_full) begin
                    n_state = FS_IDLE;
                end
            end
            default: n_state = FS_IDLE;
        endcase
    end

    assign o_job.is_write = r_is_write;
    assign o_job.wdata    = r_wdata;
    assign o_job.addr     = r_addr;
    assign o_job.status   = r_status;

endmodule

/* rtl/mdaa_fifo.sv */
module mdaa_fifo import mdaa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty,
    output logic o_full
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_job   = r_mem[r_rp];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

endmodule

/* rtl/mdaa_back.sv */
module mdaa_back import mdaa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_job,
    input  logic       i_empty,
    output logic       o_pop,
    mdaa_rsp_if.source rsp
);

    logic [ELEM_WIDTH-1:0] r_store [STORE_DEPTH];
    logic [ELEM_WIDTH-1:0] r_rd_q;
    logic [ADDR_W-1:0]     r_addr_q;
    t_status               r_status_q;
    logic                  r_zero;
    logic                  r_ovalid;
    logic                  ok;

    assign ok    = (i_job.status == ST_OK);
    assign o_pop = !i_empty && (!r_ovalid || rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (o_pop) begin
            r_ovalid <= 1'b1;
        end else if (rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (ok && i_job.is_write) begin
                r_store[i_job.addr] <= i_job.wdata;
            end
            r_rd_q     <= r_store[i_job.addr];
            r_addr_q   <= i_job.addr;
            r_status_q <= i_job.status;
            // only a good read returns store data
            r_zero     <= !(ok && !i_job.is_write);
        end
    end

    assign rsp.valid           = r_ovalid;
    assign rsp.read_data       = r_zero ? '0 : r_rd_q;
    assign rsp.element_address = r_addr_q;
    assign rsp.status          = r_status_q;

endmodule

/* rtl/multidim_array_access_core.sv */
// Row-major N-dimensional array held in a 4096 x 32 element store.
// i_req (valid/ready): one read or write per transfer, with an index for each
// dimension; indices beyond the configured dimension count are ignored.
// o_rsp (valid/ready): exactly one result per request, in request order:
// read data (zero unless a good read), linear address (zero on error), status.
// Config port: i_cfg_we writes register i_cfg_index (0 dimension count,
// 1 packed 8-bit bounds); other indexes are ignored. Each write re-derives
// the strides and the size check, during which i_req.ready is low.
// The front end checks and accumulates one dimension per cycle, stopping early
// when a check fails, then pushes the item to the queue; it takes a new
// request only after the previous item has been pushed.
// A two-entry queue separates the front end from the store and output
// register, so the front end keeps working while o_rsp is stalled; it stops
// taking requests once it holds a checked item while the queue and the output
// register are both full.
// Reset: one dimension with bound zero; store contents are undefined until
// written.
module multidim_array_access_core import mdaa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mdaa_req_if.sink              i_req,
    mdaa_rsp_if.source            o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_geom geom;
    t_job  front_job;
    t_job  back_job;
    logic  push;
    logic  pop;
    logic  q_empty;
    logic  q_full;

    mdaa_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_geom      (geom)
    );

    mdaa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .req     (i_req),
        .i_geom  (geom),
        .i_full  (q_full),
        .o_push  (push),
        .o_job   (front_job)
    );

    mdaa_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (back_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    mdaa_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (back_job),
        .i_empty (q_empty),
        .o_pop   (pop),
        .rsp     (o_rsp)
    );

endmodule

/* bench/mdaa_checker.sv */
`timescale 1ns / 1ps

// Watches request, result and register traffic, keeps a shadow of the array
// geometry and element store, and compares each result transfer in order.
module mdaa_checker import mdaa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mdaa_req_if                   i_req_tap,
    mdaa_rsp_if                   i_rsp_tap,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_mismatches,
    output int                    o_results
);

    localparam int REPORT_LIMIT = 10;

    typedef logic [MAX_DIMS-1:0][IDX_W-1:0] t_idx_vec;

    typedef struct packed {
        logic signed [ELEM_WIDTH-1:0] data;
        logic [ADDR_W-1:0]            addr;
        t_status                      status;
    } t_access_rsp;

    logic [NDIM_REG_W-1:0] dims_reg;
    logic [CFG_DATA_W-1:0] bounds_reg;
    logic [ELEM_WIDTH-1:0] shadow_store [STORE_DEPTH];
    t_access_rsp           expected_rsp_q [$];
    int                    mismatch_count = 0;
    int                    result_count = 0;

    // size check first, then bounds, then the store access at the row-major address
    function automatic t_access_rsp resolve_access(input logic is_write,
                                                   input logic [ELEM_WIDTH-1:0] value,
                                                   input t_idx_vec idx);
        t_access_rsp      res;
        int               ndims;
        int               d;
        logic [63:0]      span;
        logic [63:0]      lin;
        logic [IDX_W-1:0] bnd;
        logic             miss;
        ndims = (dims_reg == '0) ? 1 : (dims_reg > MAX_DIMS) ? MAX_DIMS : int'(dims_reg);
        span  = 64'd1;
        lin   = '0;
        miss  = 1'b0;
        // innermost first: span is the stride of dimension d when it is used
        for (d = MAX_DIMS - 1; d >= 0; d--) begin
            if (d < ndims) begin
                bnd = bounds_reg[d*IDX_W +: IDX_W];
                if (idx[d] >= bnd) begin
                    miss = 1'b1;
                end
                lin  = lin + span * idx[d];
                span = span * bnd;
            end
        end
        res = '0;
        if (span > STORE_DEPTH) begin
            res.status = ST_OVERSIZE;
        end else if (miss) begin
            res.status = ST_BOUNDS;
        end else begin
            res.status = ST_OK;
            res.addr   = lin[ADDR_W-1:0];
            if (is_write) begin
                shadow_store[lin[ADDR_W-1:0]] = value;
            end else begin
                res.data = shadow_store[lin[ADDR_W-1:0]];
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_access_rsp want;
        t_access_rsp got;
        t_idx_vec    idx;
        if (!i_rst_n) begin
            dims_reg       = NDIM_REG_W'(1);
            bounds_reg     = '0;
            mismatch_count = 0;
            result_count   = 0;
            expected_rsp_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NUM_DIMS:   dims_reg   = i_cfg_wdata[NDIM_REG_W-1:0];
                    CFG_DIM_BOUNDS: bounds_reg = i_cfg_wdata;
                    default: ;
                endcase
            end
            // results leave before new requests enter; a result never belongs
            // to a request taken at the same edge
            if (i_rsp_tap.valid && i_rsp_tap.ready) begin
                got.data   = i_rsp_tap.read_data;
                got.addr   = i_rsp_tap.element_address;
                got.status = t_status'(i_rsp_tap.status);
                result_count++;
                if (expected_rsp_q.size() == 0) begin
                    if (mismatch_count < REPORT_LIMIT) begin
                        $display("%0t: unexpected result data %0d addr %0d status %0d",
                                 $time, got.data, got.addr, got.status);
                    end
                    mismatch_count++;
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (got.data !== want.data || got.addr !== want.addr
                            || got.status !== want.status) begin
                        if (mismatch_count < REPORT_LIMIT) begin
                            $display("%0t: result %0d expected data %0d addr %0d status %0d",
                                     $time, result_count, want.data, want.addr, want.status);
                            $display("%0t: result %0d got      data %0d addr %0d status %0d",
                                     $time, result_count, got.data, got.addr, got.status);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (i_req_tap.valid && i_req_tap.ready) begin
                idx = {i_req_tap.index_7, i_req_tap.index_6, i_req_tap.index_5,
                       i_req_tap.index_4, i_req_tap.index_3, i_req_tap.index_2,
                       i_req_tap.index_1, i_req_tap.index_0};
                expected_rsp_q.push_back(resolve_access(i_req_tap.req_type,
                                                        i_req_tap.write_value, idx));
            end
        end
        o_mismatches <= mismatch_count;
        o_results    <= result_count;
    end

endmodule

/* bench/tb_multidim_array_access_core.sv */
`timescale 1ns / 1ps

module tb_multidim_array_access_core;
    import mdaa_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 6;
    localparam int ITEM_TARGET    = 1700;
    localparam int MAX_GAP        = 16;
    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_AT_RESULT = 500;
    localparam int HOLD_CYCLES    = 400;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int IDX_MAX        = (1 << IDX_W) - 1;
    localparam int NDIM_REG_MAX   = (1 << NDIM_REG_W) - 1;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // register indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef logic [MAX_DIMS-1:0][IDX_W-1:0] t_index_vec;

    typedef struct packed {
        logic                  is_write;
        logic [ELEM_WIDTH-1:0] value;
        t_index_vec            idx;
    } t_access;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    mismatches;
    int                    results_seen;

    // stimulus-side view of the geometry, used to steer reads to written cells
    int                    geo_dims;
    logic [CFG_DATA_W-1:0] geo_bounds;
    logic                  geo_open;
    t_index_vec            stored_q [$];
    int                    sent_count = 0;
    logic                  calm_send;
    int                    cycle_count = 0;

    mdaa_req_if req_ch ();
    mdaa_rsp_if rsp_ch ();

    multidim_array_access_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    mdaa_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_tap    (req_ch),
        .i_rsp_tap    (rsp_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .o_mismatches (mismatches),
        .o_results    (results_seen)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic logic lands_in_array(input t_index_vec idx);
        int d;
        for (d = 0; d < geo_dims; d++) begin
            if (idx[d] >= geo_bounds[d*IDX_W +: IDX_W]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // mostly in-range writes and reads of written cells, the rest out of range or raw
    function automatic t_access pick_access();
        t_access    a;
        t_index_vec pick;
        int         roll;
        int         d;
        a.is_write = 1'($urandom_range(0, 1));
        a.value    = $urandom;
        a.idx      = {$urandom, $urandom};
        if (!geo_open) begin
            return a;
        end
        roll = $urandom_range(0, 99);
        if (roll >= 90) begin
            // raw indices; a read landing inside could hit a cell never written
            if (lands_in_array(a.idx)) begin
                a.is_write = OP_WRITE;
            end
            return a;
        end
        for (d = 0; d < geo_dims; d++) begin
            a.idx[d] = IDX_W'($urandom_range(0, geo_bounds[d*IDX_W +: IDX_W] - 1));
        end
        if (roll < 45) begin
            a.is_write = OP_WRITE;
        end else if (roll < 78) begin
            if (stored_q.size() == 0) begin
                a.is_write = OP_WRITE;
            end else begin
                pick       = stored_q[$urandom_range(0, stored_q.size() - 1)];
                a.is_write = OP_READ;
                for (d = 0; d < geo_dims; d++) begin
                    a.idx[d] = pick[d];
                end
            end
        end else begin
            d        = $urandom_range(0, geo_dims - 1);
            a.idx[d] = IDX_W'($urandom_range(geo_bounds[d*IDX_W +: IDX_W], IDX_MAX));
        end
        return a;
    endfunction

    task automatic send_access(input t_access a);
        int gap;
        gap = calm_send ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= a.is_write;
        req_ch.write_value <= a.value;
        req_ch.index_0     <= a.idx[0];
        req_ch.index_1     <= a.idx[1];
        req_ch.index_2     <= a.idx[2];
        req_ch.index_3     <= a.idx[3];
        req_ch.index_4     <= a.idx[4];
        req_ch.index_5     <= a.idx[5];
        req_ch.index_6     <= a.idx[6];
        req_ch.index_7     <= a.idx[7];
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sent_count++;
        if (a.is_write == OP_WRITE && geo_open && lands_in_array(a.idx)) begin
            stored_q.push_back(a.idx);
        end
    endtask

    task automatic send_at(input logic op, input logic [ELEM_WIDTH-1:0] value,
                           input logic [IDX_W-1:0] i0, input logic [IDX_W-1:0] i1,
                           input logic [IDX_W-1:0] i2);
        t_access a;
        a.is_write = op;
        a.value    = value;
        a.idx      = {$urandom, $urandom};
        a.idx[0]   = i0;
        a.idx[1]   = i1;
        a.idx[2]   = i2;
        send_access(a);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (results_seen != sent_count) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        // strides are re-derived after each write
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_geometry(input logic [NDIM_REG_W-1:0] ndims,
                                  input logic [CFG_DATA_W-1:0] bounds);
        logic [63:0] span;
        int          d;
        wait_drained();
        write_reg(CFG_NUM_DIMS, CFG_DATA_W'(ndims));
        write_reg(CFG_DIM_BOUNDS, bounds);
        geo_dims   = (ndims == '0) ? 1 : (ndims > MAX_DIMS) ? MAX_DIMS : int'(ndims);
        geo_bounds = bounds;
        span       = 64'd1;
        for (d = 0; d < geo_dims; d++) begin
            span = span * geo_bounds[d*IDX_W +: IDX_W];
        end
        // zero span means some bound is zero: every access is rejected
        geo_open = (span != 0) && (span <= STORE_DEPTH);
        stored_q.delete();
    endtask

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin : rsp_side
        int   stall;
        int   taken;
        logic calm_take;
        taken     = 0;
        calm_take = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (taken % 64 == 0) begin
                calm_take = ($urandom_range(0, 3) == 0);
            end
            // one long hold-off while the sender keeps going fills the block up
            if (taken == HOLD_AT_RESULT) begin
                stall = HOLD_CYCLES;
            end else begin
                stall = calm_take ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_ch.valid) @(posedge i_clk);
            taken++;
        end
    end

    initial begin : stimulus
        logic [NDIM_REG_W-1:0] ndims;
        logic [CFG_DATA_W-1:0] bounds;
        int                    style;
        int                    cap;
        int                    budget;
        int                    b;
        int                    d;
        int                    k;
        int                    n_items;

        i_rst_n            <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_NUM_DIMS;
        cfg_wdata          <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= OP_READ;
        req_ch.write_value <= '0;
        req_ch.index_0     <= '0;
        req_ch.index_1     <= '0;
        req_ch.index_2     <= '0;
        req_ch.index_3     <= '0;
        req_ch.index_4     <= '0;
        req_ch.index_5     <= '0;
        req_ch.index_6     <= '0;
        req_ch.index_7     <= '0;
        geo_dims   = 1;
        geo_bounds = '0;
        geo_open   = 1'b0;
        calm_send  = 1'b1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: one dimension of bound zero rejects everything
        send_at(OP_WRITE, 32'h7FFF_FFFF, 8'd0, 8'd0, 8'd0);
        send_at(OP_READ, 32'h0, 8'd255, 8'd0, 8'd0);

        // 4 x 5 x 6, unused bound bytes all ones
        apply_geometry(NDIM_REG_W'(3), 64'hFFFF_FFFF_FF06_0504);
        send_at(OP_WRITE, 32'h8000_0000, 8'd0, 8'd0, 8'd0);
        send_at(OP_WRITE, 32'h7FFF_FFFF, 8'd3, 8'd4, 8'd5);
        send_at(OP_WRITE, 32'hFFFF_FFFF, 8'd1, 8'd2, 8'd3);
        send_at(OP_READ, 32'h0, 8'd0, 8'd0, 8'd0);
        send_at(OP_READ, 32'h0, 8'd3, 8'd4, 8'd5);
        send_at(OP_READ, 32'h0, 8'd1, 8'd2, 8'd3);
        send_at(OP_WRITE, 32'h1234_5678, 8'd4, 8'd0, 8'd0);
        send_at(OP_READ, 32'h0, 8'd0, 8'd5, 8'd0);
        send_at(OP_READ, 32'h0, 8'd0, 8'd0, 8'd255);
        // back-to-back write then read of the same cell
        send_at(OP_WRITE, 32'h0, 8'd3, 8'd4, 8'd5);
        send_at(OP_READ, 32'h0, 8'd3, 8'd4, 8'd5);

        // dimension count zero acts as one
        apply_geometry(NDIM_REG_W'(0), 64'h0000_0000_0000_00FF);
        send_at(OP_WRITE, $urandom, 8'd254, 8'd0, 8'd0);
        send_at(OP_READ, 32'h0, 8'd254, 8'd0, 8'd0);
        send_at(OP_READ, 32'h0, 8'd255, 8'd0, 8'd0);

        // dimension count clamps to eight; 255^8 cells cannot fit
        apply_geometry(NDIM_REG_W'(NDIM_REG_MAX), '1);
        send_at(OP_WRITE, $urandom, 8'd0, 8'd0, 8'd0);
        send_at(OP_READ, 32'h0, 8'd0, 8'd0, 8'd0);

        // 64 x 64 fills the store exactly
        apply_geometry(NDIM_REG_W'(2), 64'h0000_0000_0000_4040);
        write_reg(CFG_SPARE_B, '1);
        send_at(OP_WRITE, $urandom, 8'd63, 8'd63, 8'd0);
        send_at(OP_READ, 32'h0, 8'd63, 8'd63, 8'd0);
        send_at(OP_WRITE, $urandom, 8'd0, 8'd0, 8'd0);
        send_at(OP_READ, 32'h0, 8'd0, 8'd0, 8'd0);

        // 64 x 65 is one row too many
        apply_geometry(NDIM_REG_W'(2), 64'h0000_0000_0000_4140);
        send_at(OP_READ, 32'h0, 8'd0, 8'd0, 8'd0);

        while (sent_count < ITEM_TARGET) begin
            bounds = {$urandom, $urandom};
            style  = $urandom_range(0, 9);
            if (style == 0) begin
                ndims = NDIM_REG_W'($urandom_range(0, NDIM_REG_MAX));
            end else if (style == 8) begin
                // just past the store size
                ndims = NDIM_REG_W'(2);
                b     = $urandom_range(17, IDX_MAX);
                bounds[IDX_W-1:0]       = IDX_W'(b);
                bounds[2*IDX_W-1:IDX_W] = IDX_W'(STORE_DEPTH / b + 1);
            end else if (style == 9) begin
                // exactly the store size
                k     = $urandom_range(0, 3);
                ndims = NDIM_REG_W'((k == 0) ? 2 : (k == 1) ? 3 : (k == 2) ? 4 : 12);
                for (d = 0; d < MAX_DIMS; d++) begin
                    bounds[d*IDX_W +: IDX_W] = IDX_W'((k == 0) ? 64 : (k == 1) ? 16 :
                                                      (k == 2) ? 8 : (d < 6) ? 4 : 1);
                end
            end else begin
                ndims  = NDIM_REG_W'($urandom_range(1, MAX_DIMS));
                cap    = (ndims <= 2) ? IDX_MAX : (ndims <= 4) ? 16 : 4;
                budget = STORE_DEPTH;
                for (d = 0; d < ndims; d++) begin
                    b = $urandom_range(1, (budget < cap) ? budget : cap);
                    bounds[d*IDX_W +: IDX_W] = IDX_W'(b);
                    budget = budget / b;
                end
                if (style == 7) begin
                    d = $urandom_range(0, ndims - 1);
                    bounds[d*IDX_W +: IDX_W] = '0;
                end
                if (ndims == 1 && $urandom_range(0, 1) == 1) begin
                    ndims = '0;
                end else if (ndims == MAX_DIMS && $urandom_range(0, 1) == 1) begin
                    ndims = NDIM_REG_W'($urandom_range(MAX_DIMS + 1, NDIM_REG_MAX));
                end
            end
            apply_geometry(ndims, bounds);
            if ($urandom_range(0, 3) == 0) begin
                write_reg(($urandom_range(0, 1) == 1) ? CFG_SPARE_A : CFG_SPARE_B,
                          {$urandom, $urandom});
            end
            calm_send = ($urandom_range(0, 3) == 0);
            n_items   = $urandom_range(40, 120);
            repeat (n_items) send_access(pick_access());
        end

        wait_drained();
        if (mismatches == 0 && results_seen == sent_count) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
